[sv/dssg_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package dssg_pkg;

   // field widths
   localparam int CODE_W   = 16;
   localparam int INDEX_W  = 16;
   localparam int END_W    = 17;
   localparam int XMULT_W  = 20;
   localparam int STEP_W   = 24;
   localparam int MAX_W    = 15;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 24;

   // default queue depth between front and back
   localparam int QUEUE_DEPTH = 4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SCAN_MODE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_COUNT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_X_MAX       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_MAX       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_X_STEP      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_STEP      = 3'd5;

   // scan modes
   localparam logic MODE_LINEAR  = 1'b0;
   localparam logic MODE_DIAMOND = 1'b1;

   localparam logic [INDEX_W-1:0] FRAME_COUNT_RESET = 16'd2;

   typedef struct packed {
      logic                scan_mode;
      logic [INDEX_W-1:0]  frame_count;
      logic [MAX_W-1:0]    x_max;
      logic [MAX_W-1:0]    y_max;
      logic [STEP_W-1:0]   x_step;
      logic [STEP_W-1:0]   y_step;
   } cfg_type;

   // one classified sample handed from front to back
   typedef struct packed {
      logic signed [XMULT_W-1:0] x_mult;
      logic [INDEX_W-1:0]        y_mult;
      logic                      diamond;
      logic [INDEX_W-1:0]        sample_number;
      logic                      last;
   } entry_type;

endpackage

`default_nettype wire

[sv/dssg_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module dssg_front (
   input  wire                         clock,
   input  wire                         reset,
   input  wire dssg_pkg::cfg_type      cfg,
   input  wire                         req_valid,
   input  wire                         req_restart,
   output logic                        req_stall,
   input  wire                         queue_full,
   output logic                        push,
   output dssg_pkg::entry_type         push_data
);

   logic [dssg_pkg::INDEX_W-1:0] sample_index_ff, sample_index_in;
   logic [dssg_pkg::END_W-1:0]   line_end_ff, line_end_in;
   logic [dssg_pkg::INDEX_W-1:0] line_length_ff, line_length_in;
   logic [dssg_pkg::INDEX_W-1:0] line_number_ff, line_number_in;

   logic [dssg_pkg::INDEX_W-1:0] cur_index;
   logic [dssg_pkg::END_W-1:0]   cur_end;
   logic [dssg_pkg::INDEX_W-1:0] cur_length;
   logic [dssg_pkg::INDEX_W-1:0] cur_number;
   logic [dssg_pkg::END_W-1:0]   index_plus;
   logic [dssg_pkg::END_W-1:0]   half_frame;
   logic [dssg_pkg::INDEX_W-1:0] next_length;
   logic                         is_last;
   logic                         line_done;
   logic signed [dssg_pkg::XMULT_W-1:0] span;
   logic signed [dssg_pkg::XMULT_W-1:0] span_signed;

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   // restart makes this sample the first of the pattern
   always_comb begin
      if (req_restart) begin
         cur_index  = '0;
         cur_end    = 17'd1;
         cur_length = 16'd1;
         cur_number = '0;
      end else begin
         cur_index  = sample_index_ff;
         cur_end    = line_end_ff;
         cur_length = line_length_ff;
         cur_number = line_number_ff;
      end
   end

   // pattern end and line advance
   assign index_plus = {1'b0, cur_index} + 17'd1;
   assign half_frame = {1'b0, cfg.frame_count >> 1};
   assign is_last    = index_plus >= {1'b0, cfg.frame_count};
   assign line_done  = index_plus == cur_end;
   assign next_length = (cur_end < half_frame) ? cur_length + 16'd1 : cur_length - 16'd1;

   always_comb begin
      sample_index_in = sample_index_ff;
      line_end_in     = line_end_ff;
      line_length_in  = line_length_ff;
      line_number_in  = line_number_ff;
      if (push) begin
         if (is_last) begin
            sample_index_in = '0;
            line_end_in     = 17'd1;
            line_length_in  = 16'd1;
            line_number_in  = '0;
         end else begin
            sample_index_in = index_plus[dssg_pkg::INDEX_W-1:0];
            line_end_in     = cur_end;
            line_length_in  = cur_length;
            line_number_in  = cur_number;
            if (line_done) begin
               line_number_in = cur_number + 16'd1;
               line_length_in = next_length;
               line_end_in    = cur_end + {1'b0, next_length};
            end
         end
      end
   end

   // diamond x position offset from line center, direction by length parity
   assign span = (({3'b000, cur_end} - {4'b0000, cur_index}) <<< 1)
               - ({4'b0000, cur_length} + 20'sd1);
   assign span_signed = cur_length[0] ? -span : span;

   always_comb begin
      push_data.sample_number = cur_index;
      push_data.last          = is_last;
      push_data.diamond       = cfg.scan_mode == dssg_pkg::MODE_DIAMOND;
      if (cfg.scan_mode == dssg_pkg::MODE_DIAMOND) begin
         push_data.x_mult = span_signed;
         push_data.y_mult = cur_number;
      end else begin
         push_data.x_mult = $signed({4'b0000, cur_index});
         push_data.y_mult = cur_index;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_index_ff <= '0;
         line_end_ff     <= 17'd1;
         line_length_ff  <= 16'd1;
         line_number_ff  <= '0;
      end else begin
         sample_index_ff <= sample_index_in;
         line_end_ff     <= line_end_in;
         line_length_ff  <= line_length_in;
         line_number_ff  <= line_number_in;
      end
   end

endmodule

`default_nettype wire

[sv/dssg_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module dssg_queue #(
   parameter int DEPTH = dssg_pkg::QUEUE_DEPTH
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   push,
   input  wire dssg_pkg::entry_type push_data,
   output logic                  full,
   input  wire                   pop,
   output dssg_pkg::entry_type   pop_data,
   output logic                  empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   dssg_pkg::entry_type mem [DEPTH];

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full     = count_ff == FULL_CNT;
   assign empty    = count_ff == '0;
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

[sv/dssg_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module dssg_back (
   input  wire                         clock,
   input  wire                         reset,
   input  wire dssg_pkg::cfg_type      cfg,
   input  wire                         queue_empty,
   input  wire dssg_pkg::entry_type    pop_data,
   output logic                        pop,
   output logic                        rsp_valid,
   input  wire                         rsp_stall,
   output logic signed [15:0]          rsp_x_code,
   output logic signed [15:0]          rsp_y_code,
   output logic [15:0]                 rsp_sample_number,
   output logic                        rsp_last
);

   localparam int PX_W  = dssg_pkg::XMULT_W + dssg_pkg::STEP_W + 1;
   localparam int PY_W  = dssg_pkg::INDEX_W + dssg_pkg::STEP_W;
   localparam int ACC_W = 48;

   // clamp to the symmetric dac code range
   function automatic logic signed [15:0] sat_code(input logic signed [ACC_W-1:0] r);
      logic signed [15:0] res;
      if (r > 48'sd32767) begin
         res = 16'sd32767;
      end else if (r < -48'sd32767) begin
         res = -16'sd32767;
      end else begin
         res = r[15:0];
      end
      return res;
   endfunction

   logic                      s1_valid_ff, s1_valid_in;
   logic signed [PX_W-1:0]    s1_px_ff, s1_px_in;
   logic [PY_W-1:0]           s1_py_ff, s1_py_in;
   logic                      s1_diamond_ff;
   logic [15:0]               s1_number_ff;
   logic                      s1_last_ff;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [15:0]        rsp_x_ff, rsp_x_in;
   logic signed [15:0]        rsp_y_ff, rsp_y_in;
   logic [15:0]               rsp_number_ff;
   logic                      rsp_last_ff;

   logic                      out_en;
   logic                      s1_en;
   logic signed [ACC_W-1:0]   x_bias;
   logic signed [ACC_W-1:0]   y_bias;
   logic signed [ACC_W-1:0]   wx;
   logic signed [ACC_W-1:0]   wy;
   logic signed [ACC_W-1:0]   rx;
   logic signed [ACC_W-1:0]   ry;

   // pipeline advance
   assign out_en = !rsp_valid_ff || !rsp_stall;
   assign s1_en  = !s1_valid_ff || out_en;
   assign pop    = s1_en && !queue_empty;

   // stage one: products
   assign s1_valid_in = pop;
   assign s1_px_in = $signed(pop_data.x_mult) * $signed({1'b0, cfg.x_step});
   assign s1_py_in = pop_data.y_mult * cfg.y_step;

   // stage two: offset plus half unit, floor shift, saturate
   assign x_bias = s1_diamond_ff ? 48'sd256
                 : 48'sd128 - $signed({25'd0, cfg.x_max, 8'd0});
   assign y_bias = 48'sd128 - $signed({25'd0, cfg.y_max, 8'd0});
   assign wx = $signed({{(ACC_W-PX_W){s1_px_ff[PX_W-1]}}, s1_px_ff}) + x_bias;
   assign wy = $signed({{(ACC_W-PY_W){1'b0}}, s1_py_ff}) + y_bias;
   assign rx = s1_diamond_ff ? (wx >>> 9) : (wx >>> 8);
   assign ry = wy >>> 8;
   assign rsp_x_in = sat_code(rx);
   assign rsp_y_in = sat_code(ry);
   assign rsp_valid_in = out_en ? s1_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (s1_en) begin
         s1_px_ff      <= s1_px_in;
         s1_py_ff      <= s1_py_in;
         s1_diamond_ff <= pop_data.diamond;
         s1_number_ff  <= pop_data.sample_number;
         s1_last_ff    <= pop_data.last;
      end
      if (out_en) begin
         rsp_x_ff      <= rsp_x_in;
         rsp_y_ff      <= rsp_y_in;
         rsp_number_ff <= s1_number_ff;
         rsp_last_ff   <= s1_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s1_en) begin
            s1_valid_ff <= s1_valid_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_x_code        = rsp_x_ff;
   assign rsp_y_code        = rsp_y_ff;
   assign rsp_sample_number = rsp_number_ff;
   assign rsp_last          = rsp_last_ff;

endmodule

`default_nettype wire

[sv/diamond_serpentine_scan_generator.sv]
// rsp_valid rises once a transferred request has passed the queue write, the multiply stage
// and the output register; the rounded result transfers in a cycle with rsp_stall low
// throughput: one sample per cycle when not stalled, set by the counter update in the front
// and the one-multiply-per-stage back pipeline; the queue absorbs short output stalls
// reset: synchronous active high; clears the pattern counters, queue and pipeline,
// and returns the registers to linear mode with frame_count 2 and all else zero
`timescale 1ns / 1ps
`default_nettype none

module diamond_serpentine_scan_generator #(
   parameter int QUEUE_DEPTH = dssg_pkg::QUEUE_DEPTH
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                csr_write_enable,
   input  wire [2:0]          csr_index,
   input  wire [23:0]         csr_write_data,
   input  wire                req_valid,
   output logic               req_stall,
   input  wire                req_restart,
   output logic               rsp_valid,
   input  wire                rsp_stall,
   output logic signed [15:0] rsp_x_code,
   output logic signed [15:0] rsp_y_code,
   output logic [15:0]        rsp_sample_number,
   output logic               rsp_last
);

   dssg_pkg::cfg_type   cfg_ff, cfg_in;
   dssg_pkg::entry_type push_data;
   dssg_pkg::entry_type pop_data;
   logic                push;
   logic                pop;
   logic                queue_full;
   logic                queue_empty;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            dssg_pkg::CSR_SCAN_MODE:   cfg_in.scan_mode   = csr_write_data[0];
            dssg_pkg::CSR_FRAME_COUNT: cfg_in.frame_count = csr_write_data[15:0];
            dssg_pkg::CSR_X_MAX:       cfg_in.x_max       = csr_write_data[14:0];
            dssg_pkg::CSR_Y_MAX:       cfg_in.y_max       = csr_write_data[14:0];
            dssg_pkg::CSR_X_STEP:      cfg_in.x_step      = csr_write_data;
            dssg_pkg::CSR_Y_STEP:      cfg_in.y_step      = csr_write_data;
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.scan_mode   <= dssg_pkg::MODE_LINEAR;
         cfg_ff.frame_count <= dssg_pkg::FRAME_COUNT_RESET;
         cfg_ff.x_max       <= '0;
         cfg_ff.y_max       <= '0;
         cfg_ff.x_step      <= '0;
         cfg_ff.y_step      <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   dssg_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_valid   (req_valid),
      .req_restart (req_restart),
      .req_stall   (req_stall),
      .queue_full  (queue_full),
      .push        (push),
      .push_data   (push_data)
   );

   dssg_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (queue_empty)
   );

   dssg_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .queue_empty       (queue_empty),
      .pop_data          (pop_data),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_x_code        (rsp_x_code),
      .rsp_y_code        (rsp_y_code),
      .rsp_sample_number (rsp_sample_number),
      .rsp_last          (rsp_last)
   );

endmodule

`default_nettype wire

[tb/sv/tb.sv]
`timescale 1ns / 1ps

module tb;
   import dssg_pkg::*;

   localparam int IDLE_PCT     = 17;
   localparam int HOLD_CYCLES  = 400;
   localparam int STUCK_LIMIT  = 3000;
   localparam int DRAIN_CYCLES = 12;
   localparam int RANDOM_ITEMS = 1400;
   localparam int CALM_FROM    = 1200;
   localparam int CALM_TO      = 1800;
   localparam longint CODE_LIMIT = 32767;

   // unused slots past the register list
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_A = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_B = 3'd7;

   typedef struct {
      logic signed [CODE_W-1:0] x_code;
      logic signed [CODE_W-1:0] y_code;
      logic [INDEX_W-1:0]       sample_number;
      logic                     last;
   } scan_point_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_write_data = '0;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic                  req_restart = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic signed [15:0]    rsp_x_code;
   logic signed [15:0]    rsp_y_code;
   logic [15:0]           rsp_sample_number;
   logic                  rsp_last;

   // predicted register contents
   logic               cfg_mode;
   logic [INDEX_W-1:0] cfg_frames;
   logic [MAX_W-1:0]   cfg_x_max;
   logic [MAX_W-1:0]   cfg_y_max;
   logic [STEP_W-1:0]  cfg_x_step;
   logic [STEP_W-1:0]  cfg_y_step;

   // predicted pattern counters
   logic [INDEX_W-1:0] scan_index;
   logic [END_W-1:0]   scan_end;
   logic [INDEX_W-1:0] scan_len;
   logic [INDEX_W-1:0] scan_line;

   logic           restart_queue[$];
   scan_point_type due_points[$];

   int items_queued = 0;
   int items_sent = 0;
   int results_seen = 0;
   int patterns_seen = 0;
   int writes_done = 0;
   int errors = 0;
   int cycle_no = 0;
   int hold_left = 0;
   logic hold_done = 1'b0;
   logic hold_wanted = 1'b0;

   wire calm = (cycle_no >= CALM_FROM) && (cycle_no < CALM_TO);

   diamond_serpentine_scan_generator u_top (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_restart       (req_restart),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_x_code        (rsp_x_code),
      .rsp_y_code        (rsp_y_code),
      .rsp_sample_number (rsp_sample_number),
      .rsp_last          (rsp_last)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_no <= cycle_no + 1;
   end

   function automatic void rewind_scan();
      scan_index = '0;
      scan_end   = 17'd1;
      scan_len   = 16'd1;
      scan_line  = '0;
   endfunction

   // round to nearest with ties upward, then clamp to the symmetric code range
   function automatic logic signed [CODE_W-1:0] to_code(input longint value, input int frac);
      longint r;
      r = (value + (longint'(1) <<< (frac - 1))) >>> frac;
      if (r > CODE_LIMIT) r = CODE_LIMIT;
      if (r < -CODE_LIMIT) r = -CODE_LIMIT;
      return r[CODE_W-1:0];
   endfunction

   // next scanner position, then counter advance
   function automatic scan_point_type step_scan(input logic restart);
      scan_point_type pt;
      longint pos;
      longint span;
      longint xq;
      longint yq;
      if (restart) rewind_scan();
      pos = longint'(scan_index);
      if (cfg_mode == MODE_LINEAR) begin
         xq = pos * longint'(cfg_x_step) - longint'(cfg_x_max) * 256;
         pt.x_code = to_code(xq, 8);
         yq = pos * longint'(cfg_y_step) - longint'(cfg_y_max) * 256;
      end else begin
         // centered on the line, direction flips with line length parity
         span = 2 * (longint'(scan_end) - pos) - (longint'(scan_len) + 1);
         xq = span * longint'(cfg_x_step);
         if (scan_len[0]) xq = -xq;
         pt.x_code = to_code(xq, 9);
         yq = longint'(scan_line) * longint'(cfg_y_step) - longint'(cfg_y_max) * 256;
      end
      pt.y_code = to_code(yq, 8);
      pt.sample_number = scan_index;
      pt.last = (int'(scan_index) + 1 >= int'(cfg_frames));
      if (pt.last) begin
         rewind_scan();
      end else begin
         if (int'(scan_index) + 1 == int'(scan_end)) begin
            scan_line = scan_line + 16'd1;
            if (int'(scan_end) < int'(cfg_frames) / 2) scan_len = scan_len + 16'd1;
            else scan_len = scan_len - 16'd1;
            scan_end = scan_end + {1'b0, scan_len};
         end
         scan_index = scan_index + 16'd1;
      end
      return pt;
   endfunction

   // request driver: takes restart flags from the pending queue
   always @(posedge clock) begin
      if (reset) begin
         req_valid   <= 1'b0;
         req_restart <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            due_points.push_back(step_scan(req_restart));
            items_sent++;
         end
         if (!req_valid || !req_stall) begin
            if (restart_queue.size() > 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
               req_valid   <= 1'b1;
               req_restart <= restart_queue.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic check_field(input string field, input logic signed [31:0] want,
                              input logic signed [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
         errors++;
      end
   endtask

   // result monitor and output stall control
   always @(posedge clock) begin : monitor
      scan_point_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (rsp_last === 1'b1) patterns_seen++;
            if (due_points.size() == 0) begin
               $display("%0t: unexpected transfer, expected none actual sample %0d",
                        $time, rsp_sample_number);
               errors++;
            end else begin
               want = due_points.pop_front();
               check_field("x_code", 32'(want.x_code), 32'(rsp_x_code));
               check_field("y_code", 32'(want.y_code), 32'(rsp_y_code));
               check_field("sample_number", 32'(want.sample_number),
                           32'(rsp_sample_number));
               check_field("last", 32'(want.last), 32'(rsp_last));
            end
         end
         // one long hold-off while the sender keeps offering
         if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rsp_stall <= 1'b1;
         end else if (hold_wanted && !hold_done && restart_queue.size() > 100) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
         end
      end
   end

   // give up when no transfer happens for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STUCK_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
         else quiet++;
      end
      $display("tb: failure");
      $finish;
   end

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      case (idx)
         CSR_SCAN_MODE:   cfg_mode   = data[0];
         CSR_FRAME_COUNT: cfg_frames = data[INDEX_W-1:0];
         CSR_X_MAX:       cfg_x_max  = data[MAX_W-1:0];
         CSR_Y_MAX:       cfg_y_max  = data[MAX_W-1:0];
         CSR_X_STEP:      cfg_x_step = data[STEP_W-1:0];
         CSR_Y_STEP:      cfg_y_step = data[STEP_W-1:0];
         default: ;
      endcase
      writes_done++;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // all six registers; unused high data bits carry junk
   task automatic set_scan(input logic mode, input logic [INDEX_W-1:0] frames,
                           input logic [MAX_W-1:0] x_max, input logic [MAX_W-1:0] y_max,
                           input logic [STEP_W-1:0] x_step, input logic [STEP_W-1:0] y_step);
      logic [CSR_DATA_W-1:0] junk;
      junk = CSR_DATA_W'($urandom);
      write_reg(CSR_SCAN_MODE, {junk[23:1], mode});
      write_reg(CSR_FRAME_COUNT, {junk[23:16], frames});
      write_reg(CSR_X_MAX, {junk[23:15], x_max});
      write_reg(CSR_Y_MAX, {~junk[23:15], y_max});
      write_reg(CSR_X_STEP, x_step);
      write_reg(CSR_Y_STEP, y_step);
   endtask

   task automatic queue_items(input int count, input int restart_pct);
      for (int k = 0; k < count; k++)
         restart_queue.push_back($urandom_range(0, 99) < restart_pct);
      items_queued += count;
   endtask

   // sender pause: every queued item answered, then let the pipeline settle
   task automatic drain();
      while (results_seen < items_queued) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [MAX_W-1:0] pick_max();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return 15'h7FFF;
         default: return MAX_W'($urandom_range(0, 32767));
      endcase
   endfunction

   function automatic logic [STEP_W-1:0] pick_step();
      logic [STEP_W-1:0] raw;
      raw = STEP_W'($urandom);
      case ($urandom_range(0, 7))
         0: return '0;
         1: return 24'hFFFFFF;
         2: return STEP_W'($urandom_range(0, 1023));
         default: return raw >> $urandom_range(0, 23);
      endcase
   endfunction

   initial begin
      int random_sent;
      int odd;
      int leftover;
      logic mode;
      logic [INDEX_W-1:0] frames;

      cfg_mode   = MODE_LINEAR;
      cfg_frames = FRAME_COUNT_RESET;
      cfg_x_max  = '0;
      cfg_y_max  = '0;
      cfg_x_step = '0;
      cfg_y_step = '0;
      rewind_scan();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset defaults: two-sample linear pattern at the origin
      queue_items(2, 0);
      drain();

      // linear extremes: full negative start, saturating step, half-code ties
      set_scan(MODE_LINEAR, 16'd5, 15'h7FFF, '0, 24'hFFFFFF, 24'h000080);
      queue_items(3, 0);
      drain();

      // frame count cut below the index, then one-sample patterns
      write_reg(CSR_FRAME_COUNT, 24'd1);
      queue_items(1, 0);
      drain();
      write_reg(CSR_FRAME_COUNT, 24'd0);
      queue_items(1, 0);
      drain();

      // diamond with a frame count that is no odd square: line length runs out
      set_scan(MODE_DIAMOND, 16'd12, '0, 15'h7FFF, 24'h000180, 24'h001000);
      queue_items(12, 0);
      drain();

      // mode change mid pattern, dead register slots, frame count cut
      set_scan(MODE_DIAMOND, 16'd9, 15'd5, 15'd7, 24'h000100, 24'h000200);
      queue_items(3, 0);
      drain();
      write_reg(CSR_SCAN_MODE, {23'd0, MODE_LINEAR});
      queue_items(1, 0);
      drain();
      write_reg(CSR_SPARE_A, CSR_DATA_W'($urandom));
      write_reg(CSR_SPARE_B, CSR_DATA_W'($urandom));
      write_reg(CSR_FRAME_COUNT, 24'd2);
      queue_items(1, 0);
      drain();

      // restart in the middle of a diamond pattern
      write_reg(CSR_SCAN_MODE, {23'd0, MODE_DIAMOND});
      write_reg(CSR_FRAME_COUNT, 24'd9);
      queue_items(2, 0);
      queue_items(1, 100);
      drain();

      // start of a diamond frame at the largest frame count, with the output hold-off
      set_scan(MODE_DIAMOND, 16'hFFFF, pick_max(), pick_max(),
               STEP_W'($urandom_range(0, 24'h00FFFF)), STEP_W'($urandom_range(0, 24'h00FFFF)));
      hold_wanted = 1'b1;
      queue_items(1, 100);
      queue_items(299, 0);
      drain();

      // random phases; the pattern carries over each register change
      random_sent = 0;
      while (random_sent < RANDOM_ITEMS) begin
         mode = ($urandom_range(0, 99) < 60) ? MODE_DIAMOND : MODE_LINEAR;
         if (mode == MODE_DIAMOND && $urandom_range(0, 3) != 0) begin
            odd = 2 * $urandom_range(0, 7) + 1;
            frames = INDEX_W'(odd * odd);
         end else if ($urandom_range(0, 3) == 0) begin
            frames = INDEX_W'($urandom);
         end else begin
            frames = INDEX_W'($urandom_range(0, 120));
         end
         set_scan(mode, frames, pick_max(), pick_max(), pick_step(), pick_step());
         odd = $urandom_range(10, 150);
         queue_items(odd, ($urandom_range(0, 9) == 0) ? 30 : 3);
         random_sent += odd;
         drain();
      end

      leftover = due_points.size();
      if (leftover != 0)
         $display("%0t: results missing, expected %0d more actual 0", $time, leftover);
      $display("tb: %0d scan points checked over %0d completed patterns, %0d register writes",
               results_seen, patterns_seen, writes_done);
      $display("tb: linear and diamond modes, restarts, cut and tiny frame counts, long hold-off");
      if (errors == 0 && leftover == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
